/* design/first_fit_block_allocator_unit_assert.svh */
// Assertion macros shared by the allocator modules.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define FFBA_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication outside reset.
`define FFBA_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* design/ffba_pkg.sv */
// Package with shared types and codes for the first-fit allocator.
`default_nettype none
package ffba_pkg;
  localparam int POOL_BYTES  = 4096;
  localparam int ALIGN_BYTES = 4;

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_FREE    = 2'd1;
  localparam logic [1:0] ACT_REALLOC = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_NO_ENTRY = 2'd2;
  localparam logic [1:0] ST_ZERO     = 2'd3;

  // Scan modes selected by the controller.
  localparam logic [1:0] SM_FIT  = 2'd0;
  localparam logic [1:0] SM_FIND = 2'd1;
  localparam logic [1:0] SM_LO   = 2'd2;
  localparam logic [1:0] SM_HI   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the request
    logic scan_clr;   // reset scan index and search results
    logic scan_step;  // examine one table entry
    logic free_mark;  // clear the in-use bit of the found block
    logic merge_lo;   // fold the found block into its lower neighbor
    logic merge_hi;   // fold the upper neighbor into the current block
    logic alloc_do;   // take the first fit or carve from the top
    logic set_out;    // load the result register
  } ffba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
  } ffba_sts_t;
endpackage
`default_nettype wire

/* design/first_fit_block_allocator_unit.sv */
// Top level of the first-fit block allocator.
// Usage: an item on the in_ stream carries an action (allocate, free or
// reallocate), a requested size and a block start offset. Exactly one result
// item leaves on the out_ stream for every accepted item, carrying the
// granted offset, a status code and the free-found flag.
// Each free scans the 16-entry table once to find the block, once for a lower
// neighbor and once for an upper neighbor; each allocate scans it once for
// the first fit, and a reallocate runs the free scans and then the allocate
// scan. One entry is examined per cycle in the datapath; the unused action
// code skips the scans and goes straight to the result.
// One item is in work at a time; the next item is taken once the result has
// been handed over.
// Reset empties the table and sets the top of the pool to zero; no clearing
// pass is needed since the valid bits are flip-flops.
// When the receiver stalls, the result item holds on out_tdata until taken.
`default_nettype none
`include "first_fit_block_allocator_unit_assert.svh"
module first_fit_block_allocator_unit
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] action, [14:2] req_size, [26:15] block_addr, [31:27] zero
  input  wire logic [31:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [11:0] granted_addr, [13:12] status, [14] free_found, [15] zero
  output logic [15:0]      out_tdata
);
  ffba_cmd_t cmd;
  ffba_sts_t sts;
  logic [1:0] scan_mode;
  logic [11:0] g_addr;
  logic [1:0] st;
  logic ff;

  ffba_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .in_action(in_tdata[1:0]), .sts, .cmd, .scan_mode
  );

  ffba_datapath #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_dp (
    .clk, .rst_n, .cmd,
    .req_action(in_tdata[1:0]), .req_size(in_tdata[14:2]),
    .req_addr(in_tdata[26:15]), .scan_mode, .sts,
    .granted_addr(g_addr), .status(st), .free_found(ff)
  );

  assign out_tdata = {1'b0, ff, st, g_addr};
endmodule
`default_nettype wire

/* design/ffba_datapath.sv */
// Datapath: block table, sequential scan, split, carve and merge.
`default_nettype none
`include "first_fit_block_allocator_unit_assert.svh"
module ffba_datapath
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ffba_cmd_t   cmd,
  input  wire logic [1:0]  req_action,
  input  wire logic [12:0] req_size,
  input  wire logic [11:0] req_addr,
  input  wire logic [1:0]  scan_mode,
  output ffba_sts_t        sts,
  output logic [11:0]      granted_addr,
  output logic [1:0]       status,
  output logic             free_found
);
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int SW = $clog2(POOL_BYTES + 1) + 1;
  localparam int AW = SW;
  localparam logic [SW-1:0] POOL_C = SW'(POOL_BYTES);
  localparam logic [SW-1:0] AMASK = SW'(ALIGN_BYTES - 1);

  logic [11:0] e_start  [MAX_BLOCKS];
  logic [12:0] e_len    [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] e_use_r, e_val_r;
  logic [12:0] pool_top_r;
  logic [1:0]  act_r;
  logic [SW-1:0] size_r;
  logic [11:0] addr_r;
  logic [CW-1:0] idx_r;
  logic        best_ok_r, cur_ok_r, nb_ok_r, empty_ok_r, found_r;
  logic [IW-1:0] best_r, cur_r, nb_r, empty_r;
  logic [11:0] out_addr_r;
  logic [1:0]  out_st_r;
  logic        out_found_r;

  logic [IW-1:0] ix;
  logic [11:0] s_i;
  logic [12:0] l_i;
  logic [AW-1:0] end_i, end_cur;
  logic [SW-1:0] size_rnd;

  assign ix = idx_r[IW-1:0];
  assign s_i = e_start[ix];
  assign l_i = e_len[ix];
  assign end_i = AW'(s_i) + AW'(l_i);
  assign end_cur = AW'(e_start[cur_r]) + AW'(e_len[cur_r]);
  assign size_rnd = (SW'(req_size) + AMASK) & ~AMASK;
  assign sts.scan_last = (idx_r == CW'(MAX_BLOCKS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_use_r <= '0;
      e_val_r <= '0;
      pool_top_r <= '0;
      idx_r <= '0;
      best_ok_r <= 1'b0;
      cur_ok_r <= 1'b0;
      nb_ok_r <= 1'b0;
      empty_ok_r <= 1'b0;
      found_r <= 1'b0;
      out_addr_r <= '0;
      out_st_r <= ST_OK;
      out_found_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        act_r <= req_action;
        size_r <= (req_size == '0) ? '0 : size_rnd;
        addr_r <= req_addr;
        found_r <= 1'b0;
      end
      if (cmd.scan_clr) begin
        idx_r <= '0;
        best_ok_r <= 1'b0;
        nb_ok_r <= 1'b0;
        empty_ok_r <= 1'b0;
        if (scan_mode == SM_FIND) cur_ok_r <= 1'b0;
      end
      if (cmd.scan_step) begin
        idx_r <= idx_r + 1'b1;
        if (!e_val_r[ix] && !empty_ok_r) begin
          empty_ok_r <= 1'b1;
          empty_r <= ix;
        end
        case (scan_mode)
          SM_FIT: begin
            if (e_val_r[ix] && !e_use_r[ix] && SW'(l_i) >= size_r &&
                (!best_ok_r || s_i < e_start[best_r])) begin
              best_ok_r <= 1'b1;
              best_r <= ix;
            end
          end
          SM_FIND: begin
            if (!cur_ok_r && e_val_r[ix] && e_use_r[ix] && s_i == addr_r) begin
              cur_ok_r <= 1'b1;
              cur_r <= ix;
            end
          end
          SM_LO: begin
            if (!nb_ok_r && ix != cur_r && e_val_r[ix] && !e_use_r[ix] &&
                end_i == AW'(e_start[cur_r])) begin
              nb_ok_r <= 1'b1;
              nb_r <= ix;
            end
          end
          default: begin
            if (!nb_ok_r && ix != cur_r && e_val_r[ix] && !e_use_r[ix] &&
                end_cur == AW'(s_i)) begin
              nb_ok_r <= 1'b1;
              nb_r <= ix;
            end
          end
        endcase
      end
      if (cmd.free_mark && cur_ok_r) begin
        e_use_r[cur_r] <= 1'b0;
        found_r <= 1'b1;
      end
      // Merges only apply when a block was actually freed.
      if (cmd.merge_lo && nb_ok_r && found_r) begin
        e_len[nb_r] <= e_len[nb_r] + e_len[cur_r];
        e_val_r[cur_r] <= 1'b0;
        cur_r <= nb_r;
      end
      if (cmd.merge_hi && nb_ok_r && found_r) begin
        e_len[cur_r] <= e_len[cur_r] + e_len[nb_r];
        e_val_r[nb_r] <= 1'b0;
      end
      if (cmd.alloc_do) begin
        if (size_r == '0) begin
          out_addr_r <= '0;
          out_st_r <= ST_ZERO;
        end else if (best_ok_r) begin
          e_use_r[best_r] <= 1'b1;
          out_addr_r <= e_start[best_r];
          out_st_r <= ST_OK;
          if (SW'(e_len[best_r]) > size_r && empty_ok_r) begin
            e_val_r[empty_r] <= 1'b1;
            e_use_r[empty_r] <= 1'b0;
            e_start[empty_r] <= e_start[best_r] + 12'(size_r);
            e_len[empty_r] <= e_len[best_r] - 13'(size_r);
            e_len[best_r] <= 13'(size_r);
          end
        end else if (size_r > POOL_C || SW'(pool_top_r) > POOL_C - size_r) begin
          out_addr_r <= '0;
          out_st_r <= ST_NO_SPACE;
        end else if (!empty_ok_r) begin
          out_addr_r <= '0;
          out_st_r <= ST_NO_ENTRY;
        end else begin
          e_val_r[empty_r] <= 1'b1;
          e_use_r[empty_r] <= 1'b1;
          e_start[empty_r] <= pool_top_r[11:0];
          e_len[empty_r] <= 13'(size_r);
          pool_top_r <= pool_top_r + 13'(size_r);
          out_addr_r <= pool_top_r[11:0];
          out_st_r <= ST_OK;
        end
      end
      if (cmd.set_out) begin
        out_found_r <= found_r;
        if (act_r != ACT_ALLOC && act_r != ACT_REALLOC) begin
          out_addr_r <= '0;
          out_st_r <= ST_OK;
        end
      end
    end
  end

  assign granted_addr = out_addr_r;
  assign status = out_st_r;
  assign free_found = out_found_r;

  `FFBA_ASSERT_IMP(a_idx_range, clk, rst_n, cmd.scan_step, idx_r < CW'(MAX_BLOCKS))
  `FFBA_ASSERT_NXT(a_free_sets, clk, rst_n, cmd.free_mark && cur_ok_r, found_r)
  `FFBA_ASSERT_IMP(a_use_valid, clk, rst_n, 1'b1, (e_use_r & ~e_val_r) == '0)
endmodule
`default_nettype wire

/* design/ffba_ctrl.sv */
// Controller state machine sequencing the table scans.
`default_nettype none
`include "first_fit_block_allocator_unit_assert.svh"
module ffba_ctrl
  import ffba_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  input  wire logic [1:0] in_action,
  input  wire ffba_sts_t  sts,
  output ffba_cmd_t       cmd,
  output logic [1:0]      scan_mode
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_FIND  = 10'b0000000010,
    S_MARK  = 10'b0000000100,
    S_LO    = 10'b0000001000,
    S_HI    = 10'b0000010000,
    S_HOLD  = 10'b0000100000,
    S_MHI   = 10'b0001000000,
    S_FIT   = 10'b0010000000,
    S_ALLOC = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] act_r, act_nxt;
  logic out_v_r, out_v_nxt;

  assign in_tready = (state_r == S_IDLE) && !out_v_r;
  assign out_tvalid = out_v_r;

  always_comb begin
    state_nxt = state_r;
    act_nxt = act_r;
    out_v_nxt = out_v_r && !out_tready;
    cmd = '0;
    scan_mode = SM_FIND;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.load = 1'b1;
          cmd.scan_clr = 1'b1;
          act_nxt = in_action;
          if (in_action == ACT_FREE || in_action == ACT_REALLOC) begin
            scan_mode = SM_FIND;
            state_nxt = S_FIND;
          end else if (in_action == ACT_ALLOC) begin
            scan_mode = SM_FIT;
            state_nxt = S_FIT;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_FIND: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_MARK;
      end
      S_MARK: begin
        cmd.free_mark = 1'b1;
        cmd.scan_clr = 1'b1;
        scan_mode = SM_LO;
        state_nxt = S_LO;
      end
      S_LO: begin
        scan_mode = SM_LO;
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_HI;
      end
      S_HI: begin
        // Fold into the lower neighbor, then start the upper neighbor scan.
        cmd.merge_lo = 1'b1;
        cmd.scan_clr = 1'b1;
        scan_mode = SM_HI;
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        scan_mode = SM_HI;
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_MHI;
      end
      S_MHI: begin
        cmd.merge_hi = 1'b1;
        cmd.scan_clr = 1'b1;
        scan_mode = SM_FIT;
        state_nxt = (act_r == ACT_REALLOC) ? S_FIT : S_OUT;
      end
      S_FIT: begin
        scan_mode = SM_FIT;
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_ALLOC;
      end
      S_ALLOC: begin
        cmd.alloc_do = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.set_out = 1'b1;
        out_v_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      act_r <= ACT_ALLOC;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      act_r <= act_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  `FFBA_ASSERT_IMP(a_ready_idle, clk, rst_n, in_tready, state_r == S_IDLE)
  `FFBA_ASSERT_NXT(a_out_after, clk, rst_n, state_r == S_OUT, out_tvalid)
  `FFBA_ASSERT_IMP(a_no_ready_out, clk, rst_n, out_tvalid, !in_tready)
endmodule
`default_nettype wire
